>>> rtl/lennard_jones_pair_force_top_macros.svh
// ----------------------------------------------------------------------------
// lennard-jones pair force assertion macros
// shared assertion forms for the pair force pipeline
// ----------------------------------------------------------------------------
`ifndef LENNARD_JONES_PAIR_FORCE_TOP_MACROS_SVH
`define LENNARD_JONES_PAIR_FORCE_TOP_MACROS_SVH

// clocked assertion with explicit clock and reset
`define LJPF_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define LJPF_ASSERT(lbl, prop, msg) `LJPF_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

>>> rtl/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// lennard-jones pair force package
// constants, types and the result encoding shared by the pipeline
// ----------------------------------------------------------------------------
package ljpf_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int OUT_FRAC   = 24;
   localparam int INV_FRAC   = 40 - FRAC_BITS;
   localparam int PROD_SHIFT = FRAC_BITS + INV_FRAC - OUT_FRAC;
   localparam int E_SHIFT    = INV_FRAC - OUT_FRAC;
   localparam int RECIP_EXP  = INV_FRAC + 2 * FRAC_BITS;
   localparam int QUOT_BITS  = RECIP_EXP + 1;
   localparam int REG_BITS   = 31;
   localparam int DIV_BITS   = REG_BITS + FRAC_BITS;

   localparam logic [REG_BITS-1:0] HALF_BOX_RESET  = 31'd163840;
   localparam logic [REG_BITS-1:0] CUTOFF_SQ_RESET = 31'd409600;

   localparam logic [1:0] CSR_HALF_BOX  = 2'd0;
   localparam logic [1:0] CSR_CUTOFF_SQ = 2'd1;

   localparam logic [63:0] POS_MAX   = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAX   = 64'h0000_8000_0000_0000;
   localparam logic [47:0] POS_MAX48 = 48'h7FFF_FFFF_FFFF;

   typedef struct packed {
      logic             in_cut;
      logic             zero;
      logic [2:0]       dneg;
      logic [2:0][31:0] dmag;
   } side_type;

   typedef struct packed {
      logic        fneg;
      logic        eneg;
      logic        se;
      logic        sf;
      logic [63:0] emag;
   } sign_type;

   // clamp sign and magnitude to 48 bit two's complement, overflow flag on top
   function automatic logic [48:0] encode(input logic neg, input logic [63:0] mag);
      logic [63:0] lim;
      logic [63:0] m;
      logic        ovf;
      logic [47:0] v;
      lim = neg ? NEG_MAX : POS_MAX;
      ovf = mag > lim;
      m   = ovf ? lim : mag;
      v   = neg ? (~m[47:0] + 48'd1) : m[47:0];
      return {ovf, v};
   endfunction

endpackage

>>> rtl/lennard_jones_pair_force_top.sv
// ----------------------------------------------------------------------------
// lennard-jones pair force
// minimum image folding, cutoff and fixed point force and energy of one pair
// ----------------------------------------------------------------------------
// takes one particle pair per clock while the result side is not stalled and returns
// one result per pair, in order; the latency is set by the 57 stage radix-2
// reciprocal divider and the chain of power multipliers.
// a stall on the result side holds the whole pipeline, and nothing is lost.
// configuration may be written at any time but only while no request is in
// flight does it give defined results.
`include "lennard_jones_pair_force_top_macros.svh"

module lennard_jones_pair_force_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z, pair_energy, in_cutoff, overflow, zero fill
   output logic [199:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int FRONT = 6;
   localparam int SIDE  = 76;
   localparam int DEPTH = FRONT + SIDE;
   localparam int QB    = ljpf_pkg::QUOT_BITS;
   localparam int DB    = ljpf_pkg::DIV_BITS;

   logic                    adv;
   logic [DEPTH-1:0]        v_ff;
   logic [30:0]             half_box_ff;
   logic [30:0]             cutoff_sq_ff;

   logic [2:0][33:0]        f1_d_ff, f1_d_in;
   logic [2:0][33:0]        f2_d_ff, f2_d_in;
   logic [2:0][33:0]        f3_d_ff, f3_d_in;
   ljpf_pkg::side_type      f4_ff, f4_in;
   logic [2:0][63:0]        f5_sq_ff;
   ljpf_pkg::side_type      f5_ff;
   logic [63:0]             f6_r2_ff, f6_r2_in;
   ljpf_pkg::side_type      f6_ff;
   ljpf_pkg::side_type      s_ff [SIDE];
   ljpf_pkg::side_type      s0_in;
   logic [DB-1:0]           div_d0_ff;

   logic [DB-1:0]           div_rem_ff [QB];
   logic [QB-1:0]           div_q_ff   [QB];
   logic [DB-1:0]           div_d_ff   [QB];

   logic [QB-1:0]           x_dl  [9];
   logic [63:0]             x3_dl [6];
   logic [63:0]             x4_dl [6];
   logic [63:0]             x6_dl [3];
   logic                    s4_dl [3];
   logic                    s6_dl [3];
   logic [63:0]             x2, x3, x4, x6, x7;
   logic                    s2, s3, s4, s6, s7;

   logic [63:0]             t14_ff, t8_ff, t12_ff, t6_ff;
   logic                    se1_ff, sf1_ff;
   logic [69:0]             p14, p8, p12, p6;
   ljpf_pkg::sign_type      c2_ff, c2_in;
   logic [63:0]             fmag_ff, fmag_in;
   ljpf_pkg::sign_type      c_dl [3];
   logic [2:0][63:0]        fq;
   logic [2:0]              fsat;

   logic [2:0][47:0]        force_ff, force_in;
   logic [47:0]             pair_energy_ff, pair_energy_in;
   logic                    in_cut_ff, in_cut_in;
   logic                    overflow_ff, overflow_in;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = v_ff[DEPTH-1];
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {6'd0, overflow_ff, in_cut_ff, pair_energy_ff,
                        force_ff[2], force_ff[1], force_ff[0]};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_box_ff  <= ljpf_pkg::HALF_BOX_RESET;
         cutoff_sq_ff <= ljpf_pkg::CUTOFF_SQ_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ljpf_pkg::CSR_HALF_BOX:  half_box_ff  <= csr_data[30:0];
            ljpf_pkg::CSR_CUTOFF_SQ: cutoff_sq_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // displacement and minimum image folding
   always_comb begin
      logic [33:0] h;
      logic [33:0] h2;
      logic [33:0] neg_d;
      h  = {3'd0, half_box_ff};
      h2 = {2'd0, half_box_ff, 1'b0};
      f4_in = '0;
      for (int i = 0; i < 3; i++) begin
         f1_d_in[i] = {{2{req_tdata[32*i+31]}}, req_tdata[32*i +: 32]}
                    - {{2{req_tdata[32*(i+3)+31]}}, req_tdata[32*(i+3) +: 32]};
         f2_d_in[i] = ($signed(f1_d_ff[i]) > $signed(h)) ? f1_d_ff[i] - h2 : f1_d_ff[i];
         f3_d_in[i] = ($signed(f2_d_ff[i]) < -$signed(h)) ? f2_d_ff[i] + h2 : f2_d_ff[i];
         neg_d      = -f3_d_ff[i];
         f4_in.dneg[i] = f3_d_ff[i][33];
         f4_in.dmag[i] = f3_d_ff[i][33] ? neg_d[31:0] : f3_d_ff[i][31:0];
      end
   end

   // squared distance and cutoff test
   always_comb begin
      logic [65:0] sum;
      sum = {2'd0, f5_sq_ff[0]} + {2'd0, f5_sq_ff[1]} + {2'd0, f5_sq_ff[2]};
      f6_r2_in = (|sum[65:64]) ? '1 : sum[63:0];
      s0_in        = f6_ff;
      s0_in.in_cut = f6_r2_ff <= (64'(cutoff_sq_ff) << ljpf_pkg::FRAC_BITS);
      s0_in.zero   = f6_r2_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_d_ff <= f1_d_in;
         f2_d_ff <= f2_d_in;
         f3_d_ff <= f3_d_in;
         f4_ff   <= f4_in;
         for (int i = 0; i < 3; i++) begin
            f5_sq_ff[i] <= f4_ff.dmag[i] * f4_ff.dmag[i];
         end
         f5_ff     <= f4_ff;
         f6_r2_ff  <= f6_r2_in;
         f6_ff     <= f5_ff;
         s_ff[0]   <= s0_in;
         div_d0_ff <= f6_r2_ff[DB-1:0];
         for (int j = 1; j < SIDE; j++) begin
            s_ff[j] <= s_ff[j-1];
         end
      end
   end

   // reciprocal divider, one quotient bit a stage
   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [DB-1:0] rem_prev;
      logic [QB-1:0] q_prev;
      logic [DB-1:0] d_prev;
      logic [DB:0]   t;
      logic [DB:0]   diff;
      logic          ge;
      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign q_prev   = '0;
         assign d_prev   = div_d0_ff;
         assign t        = {rem_prev, 1'b1};
      end else begin : g_next
         assign rem_prev = div_rem_ff[j-1];
         assign q_prev   = div_q_ff[j-1];
         assign d_prev   = div_d_ff[j-1];
         assign t        = {rem_prev, 1'b0};
      end
      assign ge   = t >= {1'b0, d_prev};
      assign diff = t - {1'b0, d_prev};
      always_ff @(posedge clock) begin
         if (adv) begin
            div_rem_ff[j] <= ge ? diff[DB-1:0] : t[DB-1:0];
            div_q_ff[j]   <= {q_prev[QB-2:0], ge};
            div_d_ff[j]   <= d_prev;
         end
      end
   end

   // powers of the reciprocal
   ljpf_mul u_mul_x2 (
      .clock(clock), .adv(adv),
      .a(64'(div_q_ff[QB-1])), .b(64'(div_q_ff[QB-1])), .sat_in(1'b0),
      .q(x2), .sat(s2)
   );

   ljpf_mul u_mul_x3 (
      .clock(clock), .adv(adv), .a(x2), .b(64'(x_dl[2])), .sat_in(s2),
      .q(x3), .sat(s3)
   );

   ljpf_mul u_mul_x4 (
      .clock(clock), .adv(adv), .a(x2), .b(x2), .sat_in(1'b0),
      .q(x4), .sat(s4)
   );

   ljpf_mul u_mul_x6 (
      .clock(clock), .adv(adv), .a(x3), .b(x3), .sat_in(s3),
      .q(x6), .sat(s6)
   );

   ljpf_mul u_mul_x7 (
      .clock(clock), .adv(adv), .a(x6), .b(64'(x_dl[8])), .sat_in(s4_dl[2]),
      .q(x7), .sat(s7)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         x_dl[0]  <= div_q_ff[QB-1];
         x3_dl[0] <= x3;
         x4_dl[0] <= x4;
         x6_dl[0] <= x6;
         s4_dl[0] <= s4;
         s6_dl[0] <= s6;
         for (int k = 1; k < 9; k++) x_dl[k] <= x_dl[k-1];
         for (int k = 1; k < 6; k++) begin
            x3_dl[k] <= x3_dl[k-1];
            x4_dl[k] <= x4_dl[k-1];
         end
         for (int k = 1; k < 3; k++) begin
            x6_dl[k] <= x6_dl[k-1];
            s4_dl[k] <= s4_dl[k-1];
            s6_dl[k] <= s6_dl[k-1];
         end
      end
   end

   // constant factors and differences
   always_comb begin
      p14 = ({6'd0, x7} << 5) + ({6'd0, x7} << 4);
      p8  = ({6'd0, x4_dl[5]} << 4) + ({6'd0, x4_dl[5]} << 3);
      p12 = {6'd0, x6_dl[2]} << 2;
      p6  = {6'd0, x3_dl[5]} << 2;
      c2_in.fneg = t14_ff < t8_ff;
      c2_in.eneg = t12_ff < t6_ff;
      c2_in.se   = se1_ff;
      c2_in.sf   = sf1_ff;
      c2_in.emag = c2_in.eneg ? t6_ff - t12_ff : t12_ff - t6_ff;
      fmag_in    = c2_in.fneg ? t8_ff - t14_ff : t14_ff - t8_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t14_ff  <= (|p14[69:64]) ? '1 : p14[63:0];
         t8_ff   <= (|p8[69:64])  ? '1 : p8[63:0];
         t12_ff  <= (|p12[69:64]) ? '1 : p12[63:0];
         t6_ff   <= (|p6[69:64])  ? '1 : p6[63:0];
         se1_ff  <= s6_dl[2] | (|p12[69:64]) | (|p6[69:64]);
         sf1_ff  <= s6_dl[2] | s7 | (|p14[69:64]) | (|p8[69:64]);
         c2_ff   <= c2_in;
         fmag_ff <= fmag_in;
         c_dl[0] <= c2_ff;
         c_dl[1] <= c_dl[0];
         c_dl[2] <= c_dl[1];
      end
   end

   // force components
   for (genvar i = 0; i < 3; i++) begin : g_force
      ljpf_mul #(.SHIFT_BITS(ljpf_pkg::PROD_SHIFT)) u_mul_f (
         .clock(clock), .adv(adv), .a(64'(s_ff[71].dmag[i])), .b(fmag_ff),
         .sat_in(1'b0), .q(fq[i]), .sat(fsat[i])
      );
   end

   // clamp and special cases
   always_comb begin
      logic [48:0] enc;
      logic [63:0] mag;
      logic        neg;
      logic        ovf;
      ovf = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (c_dl[2].sf) begin
            mag = (s_ff[74].dmag[i] != '0) ? '1 : '0;
            neg = s_ff[74].dneg[i];
         end else begin
            mag = fsat[i] ? '1 : fq[i];
            neg = s_ff[74].dneg[i] ^ c_dl[2].fneg;
         end
         enc = ljpf_pkg::encode(neg, mag);
         force_in[i] = enc[47:0];
         ovf = ovf | enc[48];
      end
      if (c_dl[2].se) begin
         enc = ljpf_pkg::encode(1'b0, '1);
      end else begin
         enc = ljpf_pkg::encode(c_dl[2].eneg, c_dl[2].emag >> ljpf_pkg::E_SHIFT);
      end
      pair_energy_in = enc[47:0];
      ovf = ovf | enc[48];
      in_cut_in   = s_ff[74].in_cut;
      overflow_in = ovf;
      if (!s_ff[74].in_cut) begin
         force_in       = '0;
         pair_energy_in = '0;
         overflow_in    = 1'b0;
      end else if (s_ff[74].zero) begin
         force_in       = '0;
         pair_energy_in = ljpf_pkg::POS_MAX48;
         overflow_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         force_ff       <= force_in;
         pair_energy_ff <= pair_energy_in;
         in_cut_ff      <= in_cut_in;
         overflow_ff    <= overflow_in;
      end
   end

   `LJPF_ASSERT(a_beyond_cutoff_zero, rsp_tvalid && !in_cut_ff |-> (force_ff == '0) && (pair_energy_ff == '0) && !overflow_ff, "result beyond cutoff is not zero")
   `LJPF_ASSERT(a_zero_distance, v_ff[DEPTH-2] && s_ff[74].in_cut && s_ff[74].zero && adv |=> overflow_ff && (pair_energy_ff == ljpf_pkg::POS_MAX48) && (force_ff == '0), "zero distance result wrong")
   `LJPF_ASSERT(a_recip_nonzero, v_ff[FRONT+57] && s_ff[57].in_cut && !s_ff[57].zero |-> div_q_ff[QB-1] != '0, "reciprocal is zero inside cutoff")
   `LJPF_ASSERT(a_stall_freeze, !adv |=> $stable(x_dl[8]) && $stable(c2_ff), "pipeline moved during stall")

endmodule

>>> rtl/ljpf_mul.sv
// ----------------------------------------------------------------------------
// lennard-jones pair force multiplier
// 64 x 64 unsigned multiply, shift right and saturate, three register stages
// ----------------------------------------------------------------------------
module ljpf_mul #(
   parameter int SHIFT_BITS = ljpf_pkg::INV_FRAC
) (
   input  logic        clock,
   input  logic        adv,
   input  logic [63:0] a,
   input  logic [63:0] b,
   input  logic        sat_in,
   output logic [63:0] q,
   output logic        sat
);

   logic [3:0][63:0] pp_ff;
   logic             s1_ff;
   logic [127:0]     p_ff;
   logic [127:0]     p_in;
   logic             s2_ff;
   logic [63:0]      q_ff;
   logic [63:0]      q_in;
   logic             sat_ff;
   logic             hi_nz;

   always_comb begin
      p_in = {64'd0, pp_ff[0]} + ({64'd0, pp_ff[1]} << 32) + ({64'd0, pp_ff[2]} << 32)
           + {pp_ff[3], 64'd0};
   end

   always_comb begin
      hi_nz = |p_ff[127:64+SHIFT_BITS];
      q_in  = hi_nz ? '1 : p_ff[63+SHIFT_BITS:SHIFT_BITS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff[0] <= a[31:0]  * b[31:0];
         pp_ff[1] <= a[31:0]  * b[63:32];
         pp_ff[2] <= a[63:32] * b[31:0];
         pp_ff[3] <= a[63:32] * b[63:32];
         s1_ff    <= sat_in;
         p_ff     <= p_in;
         s2_ff    <= s1_ff;
         q_ff     <= q_in;
         sat_ff   <= s2_ff | hi_nz;
      end
   end

   assign q   = q_ff;
   assign sat = sat_ff;

endmodule
